// ===== hdl/pol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared widths, opcode codes and parameter defaults for the positional list
// no dependencies
package pol_pkg;

   // fixed field widths of the request and response words
   localparam int OPCODE_W   = 3;
   localparam int POS_W      = 5;
   localparam int VALUE_W    = 32;
   localparam int DATA_OUT_W = 32;
   localparam int INDEX_W    = 5;
   localparam int LENGTH_W   = 5;

   // parameter defaults
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef logic [OPCODE_W-1:0] opcode_type;

   localparam opcode_type OP_INSERT = 3'd0;
   localparam opcode_type OP_DELETE = 3'd1;
   localparam opcode_type OP_GET    = 3'd2;
   localparam opcode_type OP_LOCATE = 3'd3;
   localparam opcode_type OP_CLEAR  = 3'd4;

endpackage
`default_nettype wire

// ===== hdl/pol_ifc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channel interfaces for list requests and responses
// depends on pol_pkg for field widths
interface pol_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [pol_pkg::OPCODE_W-1:0]         opcode;
   logic [pol_pkg::POS_W-1:0]            position;
   logic signed [pol_pkg::VALUE_W-1:0]   value;

   modport source (output valid, opcode, position, value, input ready);
   modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface pol_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  status;
   logic signed [pol_pkg::DATA_OUT_W-1:0] data_out;
   logic [pol_pkg::INDEX_W-1:0]           found_index;
   logic [pol_pkg::LENGTH_W-1:0]          length;
   logic                                  empty_res;

   modport source (output valid, status, data_out, found_index, length, empty_res,
                   input ready);
   modport sink   (input valid, status, data_out, found_index, length, empty_res,
                   output ready);
endinterface
`default_nettype wire

// ===== hdl/positional_ordered_list_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// positional ordered list: bounded list of signed words addressed by 1-based position
// depends on pol_pkg and the channel interfaces in pol_ifc.sv
//
// usage
//  - req_ch carries one request word: opcode, position, value
//    (insert before, delete at, get at, locate first match, clear)
//  - rsp_ch returns exactly one response word per request: status, data_out,
//    found_index, length after the operation and empty flag
//  - the elements live in one memory with a registered read port; insert and
//    delete move entries one per cycle (read one entry, write its neighbor),
//    locate scans one entry per cycle and stops at the first hit
//  - clear and rejected requests skip the shift pass and go straight to the
//    finish state; the other requests first move or scan entries in ST_SHIFT
//  - one request is worked on at a time and the next one is taken the cycle
//    after the response is loaded, so a new word waits until the last one is
//    through its one-entry-per-cycle moves through the single read port
//  - req_ch.ready is high whenever no request is in progress; a new request is
//    taken while the previous response still waits in the output register
//  - a stalled receiver holds the response word; a finished request waits for
//    the output register to free up before the block goes back to idle
//  - reset empties the list (length 0) and drops any pending response; the
//    memory contents are not cleared, no entry is read before it is written
module positional_ordered_list_core #(
   parameter int DEPTH      = pol_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   pol_req_if.sink    req_ch,
   pol_rsp_if.source  rsp_ch
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   // width that holds both a position and a count, plus headroom for +1
   localparam int XW    = ((CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // element memory, one write and one registered read per cycle
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control state
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       left_ff, left_in;      // reads still to issue
   logic                   pend_ff, pend_in;      // read data arrives this cycle
   logic                   rsp_valid_ff, rsp_valid_in;

   // request context and result being built
   pol_pkg::opcode_type    op_ff, op_in;
   logic [AW-1:0]          tgt_ff, tgt_in;        // insert slot / first delete slot
   logic [DATA_WIDTH-1:0]  val_ff, val_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          pend_addr_ff, pend_addr_in;
   logic [DATA_WIDTH-1:0]  data_ff, data_in;
   logic [CNT_W-1:0]       found_ff, found_in;
   logic                   status_ff, status_in;

   // response output register
   logic                           rsp_status_ff, rsp_status_in;
   logic [pol_pkg::DATA_OUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pol_pkg::INDEX_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [pol_pkg::LENGTH_W-1:0]   rsp_length_ff, rsp_length_in;
   logic                           rsp_empty_ff, rsp_empty_in;

   logic          req_fire;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic          pos_ok_ins;
   logic          pos_ok_rd;
   logic          hit;
   logic          out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign pos_x      = XW'(req_ch.position);
   assign cnt_x      = XW'(count_ff);
   // insert may go one past the end, but not into a full store
   assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(DEPTH));
   assign pos_ok_rd  = (pos_x != '0) && (pos_x <= cnt_x);

   // locate compare on the word read last cycle
   assign hit = pend_ff && (op_ff == pol_pkg::OP_LOCATE) && (found_ff == '0) &&
                (rd_data_ff == val_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      op_in         = op_ff;
      tgt_in        = tgt_ff;
      val_in        = val_ff;
      ptr_in        = ptr_ff;
      pend_addr_in  = pend_addr_ff;
      data_in       = data_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = tgt_ff;
      wr_data       = val_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_ch.opcode;
               val_in    = DATA_WIDTH'(req_ch.value);   // sign extend or truncate
               tgt_in    = AW'(pos_x - XW'(1));
               data_in   = '0;
               found_in  = '0;
               status_in = 1'b0;
               state_in  = ST_SHIFT;
               case (req_ch.opcode)
                  pol_pkg::OP_INSERT: begin
                     if (pos_ok_ins) begin
                        // move entries n-1 down to pos-1 up by one
                        ptr_in   = AW'(cnt_x - XW'(1));
                        left_in  = CNT_W'(cnt_x - pos_x + XW'(1));
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        status_in = 1'b1;
                        state_in  = ST_FINISH;
                     end
                  end
                  pol_pkg::OP_DELETE: begin
                     if (pos_ok_rd) begin
                        // read the removed entry, then move the tail down by one
                        ptr_in   = AW'(pos_x - XW'(1));
                        left_in  = CNT_W'(cnt_x - pos_x + XW'(1));
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        status_in = 1'b1;
                        state_in  = ST_FINISH;
                     end
                  end
                  pol_pkg::OP_GET: begin
                     if (pos_ok_rd) begin
                        ptr_in  = AW'(pos_x - XW'(1));
                        left_in = CNT_W'(1);
                     end else begin
                        status_in = 1'b1;
                        state_in  = ST_FINISH;
                     end
                  end
                  pol_pkg::OP_LOCATE: begin
                     ptr_in  = '0;
                     left_in = count_ff;
                  end
                  pol_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     status_in = 1'b1;
                     state_in  = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // retire the read issued last cycle
            if (pend_ff) begin
               case (op_ff)
                  pol_pkg::OP_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_addr_ff + AW'(1);
                     wr_data = rd_data_ff;
                  end
                  pol_pkg::OP_DELETE: begin
                     if (pend_addr_ff == tgt_ff) begin
                        data_in = rd_data_ff;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pend_addr_ff - AW'(1);
                        wr_data = rd_data_ff;
                     end
                  end
                  pol_pkg::OP_GET: begin
                     data_in = rd_data_ff;
                  end
                  pol_pkg::OP_LOCATE: begin
                     if (hit) begin
                        found_in = CNT_W'(pend_addr_ff) + CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // issue the next read; a locate hit stops the scan
            if (left_ff != '0 && !hit) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               left_in      = left_ff - CNT_W'(1);
               ptr_in       = (op_ff == pol_pkg::OP_INSERT) ? ptr_ff - AW'(1)
                                                            : ptr_ff + AW'(1);
            end else if (hit) begin
               left_in = '0;
            end else if (!pend_ff) begin
               // all moves done: drop the new word into its slot
               if (op_ff == pol_pkg::OP_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = tgt_ff;
                  wr_data = val_ff;
               end
               if (op_ff == pol_pkg::OP_LOCATE) begin
                  status_in = (found_ff == '0);
               end
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = pol_pkg::DATA_OUT_W'(data_ff);
               rsp_found_in  = pol_pkg::INDEX_W'(found_ff);
               rsp_length_in = pol_pkg::LENGTH_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tgt_ff        <= tgt_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      pend_addr_ff  <= pend_addr_in;
      data_ff       <= data_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
      rsp_empty_ff  <= rsp_empty_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.data_out    = rsp_data_ff;
   assign rsp_ch.found_index = rsp_found_ff;
   assign rsp_ch.length      = rsp_length_ff;
   assign rsp_ch.empty_res   = rsp_empty_ff;

   // the memory is only touched while a request is being worked on
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SHIFT) |-> !wr_en)
      else $error("memory write outside of a shift pass");

   // every write lands inside the store
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < DEPTH))
      else $error("memory write beyond depth");

   // the length only moves when a request is accepted
   a_count_on_accept: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> (count_ff == $past(count_ff)))
      else $error("length changed without an accepted request");

   // a located index always comes with an ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_found_ff != '0)) |-> !rsp_status_ff)
      else $error("found index reported with error status");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for positional_ordered_list_core: insert, delete, get, locate, clear
// depends on pol_pkg (hdl/pol_pkg.sv), the channel interfaces (hdl/pol_ifc.sv) and the core
module testbench;
   import pol_pkg::*;

   localparam int DEPTH      = DEPTH_DEFAULT;
   localparam int DATA_WIDTH = DATA_WIDTH_DEFAULT;

   // run shape
   localparam int RANDOM_WORDS = 750;
   localparam int IDLE_PCT     = 18;
   localparam int QUIET_FIRST  = 350;            // no idling on either side while
   localparam int QUIET_LAST   = 470;            // words_sent sits in this window
   localparam int FILL_SPAN    = 48;             // random words per fill or drain stretch
   localparam int DRAIN_CYCLES = DEPTH + 24;     // worst move or scan plus slack
   localparam int CYCLE_LIMIT  = 200000;

   // opcodes past clear have no meaning and must come back as errors
   localparam opcode_type OP_RESERVED_LO = OP_CLEAR + 3'd1;
   localparam opcode_type OP_RESERVED_HI = '1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef struct packed {
      opcode_type                 opcode;
      logic [POS_W-1:0]           position;
      logic signed [VALUE_W-1:0]  value;
   } list_req_t;

   typedef struct packed {
      logic                          status;
      logic signed [DATA_OUT_W-1:0]  data_out;
      logic [INDEX_W-1:0]            found_index;
      logic [LENGTH_W-1:0]           length;
      logic                          empty_res;
   } list_rsp_t;

   // full contents of the list: element count plus the stored words
   typedef struct packed {
      logic [LENGTH_W-1:0]                count;
      logic [DEPTH-1:0][DATA_WIDTH-1:0]   words;
   } list_image_t;

   typedef struct packed {
      list_image_t after;
      list_rsp_t   rsp;
   } list_step_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pol_req_if req_ch ();
   pol_rsp_if rsp_ch ();

   positional_ordered_list_core #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // request words waiting to be driven, response words waiting to arrive
   list_req_t   request_q[$];
   list_rsp_t   response_q[$];

   // plan_list follows the list as the stimulus is built, so that positions and
   // locate values can be aimed; shadow_list follows it word by word at acceptance
   list_image_t plan_list   = '0;
   list_image_t shadow_list = '0;

   int error_count     = 0;
   int words_sent      = 0;
   int words_checked   = 0;
   int cycle_count     = 0;
   int peak_length     = 0;
   int full_rejects    = 0;
   int error_responses = 0;
   int op_seen [0:7]   = '{default: 0};

   // ---------------------------------------------------------------------------
   // list behavior: one request word in, the list after it and the response out
   // ---------------------------------------------------------------------------
   function automatic list_step_t apply_request(list_image_t img, list_req_t w);
      list_step_t               o;
      int                       p;
      int                       cnt;
      int                       k;
      logic [DATA_WIDTH-1:0]    v;
      o     = '0;
      o.after = img;
      p     = int'(w.position);
      cnt   = int'(img.count);
      v     = DATA_WIDTH'(w.value);       // kept in the low DATA_WIDTH bits
      case (w.opcode)
         OP_INSERT: begin
            // position may be one past the tail; a full list turns every insert away
            if (p < 1 || p > cnt + 1 || cnt >= DEPTH) begin
               o.rsp.status = STATUS_ERROR;
            end else begin
               for (k = cnt; k >= p; k--)
                  o.after.words[k] = img.words[k-1];
               o.after.words[p-1] = v;
               o.after.count      = img.count + 1'b1;
            end
         end
         OP_DELETE: begin
            if (p < 1 || p > cnt) begin
               o.rsp.status = STATUS_ERROR;
            end else begin
               o.rsp.data_out = DATA_OUT_W'(img.words[p-1]);
               for (k = p; k < cnt; k++)
                  o.after.words[k-1] = img.words[k];
               o.after.count = img.count - 1'b1;
            end
         end
         OP_GET: begin
            if (p < 1 || p > cnt)
               o.rsp.status = STATUS_ERROR;
            else
               o.rsp.data_out = DATA_OUT_W'(img.words[p-1]);
         end
         OP_LOCATE: begin
            // first match wins, a miss is an error with index zero
            for (k = 0; k < cnt; k++) begin
               if (o.rsp.found_index == '0 && img.words[k] == v)
                  o.rsp.found_index = INDEX_W'(k + 1);
            end
            if (o.rsp.found_index == '0)
               o.rsp.status = STATUS_ERROR;
         end
         OP_CLEAR: begin
            o.after.count = '0;
         end
         default: begin
            o.rsp.status = STATUS_ERROR;
         end
      endcase
      o.rsp.length    = o.after.count;
      o.rsp.empty_res = (o.after.count == '0);
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------
   task automatic plan_word(input opcode_type op, input int pos,
                            input logic signed [VALUE_W-1:0] val);
      list_req_t  w;
      list_step_t s;
      w.opcode   = op;
      w.position = POS_W'(pos);
      w.value    = val;
      request_q.push_back(w);
      s         = apply_request(plan_list, w);
      plan_list = s.after;
   endtask

   // a small pool of values makes duplicates and locate hits common
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 99) >= 45)
         return $urandom;
      case ($urandom_range(0, 5))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         4:       return VALUE_W'(1);
         default: return VALUE_W'(32'h5a5a_5a5a);
      endcase
   endfunction

   // filling stretches lean on insert until the list runs full, draining ones on delete
   task automatic plan_random_word(input bit filling);
      int                         r;
      int                         p;
      int                         cnt;
      opcode_type                 op;
      logic signed [VALUE_W-1:0]  v;
      cnt = int'(plan_list.count);
      r   = $urandom_range(0, 99);
      if (r < (filling ? 55 : 20))
         op = OP_INSERT;
      else if (r < (filling ? 70 : 55))
         op = OP_DELETE;
      else if (r < (filling ? 82 : 72))
         op = OP_GET;
      else if (r < (filling ? 95 : 94))
         op = OP_LOCATE;
      else if (r < (filling ? 97 : 96))
         op = OP_CLEAR;
      else
         op = opcode_type'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      // mostly a position that lands in range, otherwise anything the field holds
      p = $urandom_range(0, (1 << POS_W) - 1);
      if ($urandom_range(0, 99) < 85) begin
         if (op == OP_INSERT)
            p = $urandom_range(1, cnt + 1);
         else if ((op == OP_DELETE || op == OP_GET) && cnt > 0)
            p = $urandom_range(1, cnt);
      end
      v = pick_value();
      if (op == OP_LOCATE && cnt > 0 && $urandom_range(0, 99) < 70)
         v = plan_list.words[$urandom_range(0, cnt - 1)];
      plan_word(op, p, v);
   endtask

   // ---------------------------------------------------------------------------
   // request driver: presents the next word once the current one is taken
   // ---------------------------------------------------------------------------
   function automatic bit no_idle_window();
      return words_sent >= QUIET_FIRST && words_sent < QUIET_LAST;
   endfunction

   always @(posedge clock) begin : drive_requests
      list_req_t  w;
      list_step_t step;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         // word on the bus is accepted at this edge: update the shadow list
         if (req_ch.valid && req_ch.ready) begin
            w.opcode   = req_ch.opcode;
            w.position = req_ch.position;
            w.value    = req_ch.value;
            step = apply_request(shadow_list, w);
            if (w.opcode == OP_INSERT && step.rsp.status == STATUS_ERROR
                && int'(shadow_list.count) == DEPTH)
               full_rejects++;
            if (step.rsp.status == STATUS_ERROR)
               error_responses++;
            shadow_list = step.after;
            if (int'(shadow_list.count) > peak_length)
               peak_length = int'(shadow_list.count);
            response_q.push_back(step.rsp);
            op_seen[w.opcode]++;
            words_sent++;
         end
         // bus free: present the next word or leave the bus idle
         if (!req_ch.valid || req_ch.ready) begin
            if (request_q.size() != 0
                && (no_idle_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
               w = request_q.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.opcode   <= w.opcode;
               req_ch.position <= w.position;
               req_ch.value    <= w.value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor: checks each accepted word against the oldest prediction
   // ---------------------------------------------------------------------------
   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch on response %0d, expected %0d, actual %0d",
                  $time, field, words_checked, want, got);
      end
   endtask

   always @(posedge clock) begin : check_responses
      list_rsp_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (response_q.size() == 0) begin
               error_count++;
               $display("%0t: response word with no request outstanding", $time);
            end else begin
               want = response_q.pop_front();
               check_field("status",      want.status,      rsp_ch.status);
               check_field("data_out",    want.data_out,    rsp_ch.data_out);
               check_field("found_index", want.found_index, rsp_ch.found_index);
               check_field("length",      want.length,      rsp_ch.length);
               check_field("empty_res",   want.empty_res,   rsp_ch.empty_res);
               words_checked++;
            end
         end
         rsp_ch.ready <= no_idle_window() || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still outstanding",
                  cycle_count, response_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------------
   initial begin : run
      int i;
      int unused_ops;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = OP_CLEAR;
      req_ch.position = '0;
      req_ch.value    = '0;
      rsp_ch.ready    = 1'b0;

      // empty list: clear, then a get, a delete and a locate that all miss
      plan_word(OP_CLEAR,  0, '0);
      plan_word(OP_GET,    1, '0);
      plan_word(OP_DELETE, 1, '0);
      plan_word(OP_LOCATE, 0, '0);
      // insert at position zero and past the tail
      plan_word(OP_INSERT, 0, VALUE_MAX);
      plan_word(OP_INSERT, 2, VALUE_MAX);
      // build [0, min, 5a5a5a5a, max, -1] through head, tail and middle inserts
      plan_word(OP_INSERT, 1, VALUE_MIN);
      plan_word(OP_INSERT, 2, VALUE_MAX);
      plan_word(OP_INSERT, 1, '0);
      plan_word(OP_INSERT, 4, '1);
      plan_word(OP_INSERT, 3, VALUE_W'(32'h5a5a_5a5a));
      // get at zero, at the tail, past the tail and at the top of the field
      plan_word(OP_GET, 0,  '0);
      plan_word(OP_GET, 5,  '0);
      plan_word(OP_GET, 6,  '0);
      plan_word(OP_GET, 31, '1);
      // locate a hit inside the list, a hit at the head and a miss
      plan_word(OP_LOCATE, 0, VALUE_MAX);
      plan_word(OP_LOCATE, 0, '0);
      plan_word(OP_LOCATE, 0, VALUE_W'(12345));
      // delete out of range, then from the middle and the head
      plan_word(OP_DELETE, 0, '0);
      plan_word(OP_DELETE, 6, '0);
      plan_word(OP_DELETE, 3, '0);
      // opcodes with no meaning
      for (i = OP_RESERVED_LO; i <= OP_RESERVED_HI; i++)
         plan_word(opcode_type'(i), 31, $urandom);
      plan_word(OP_DELETE, 1, '0);

      for (i = 0; i < RANDOM_WORDS; i++)
         plan_random_word((i / FILL_SPAN) % 2 == 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to go out and every response to come back
      while (request_q.size() != 0 || req_ch.valid || response_q.size() != 0)
         @(posedge clock);
      // let any stray response show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      unused_ops = 0;
      for (i = OP_RESERVED_LO; i <= OP_RESERVED_HI; i++)
         unused_ops += op_seen[i];
      $display("run covered %0d words: %0d insert, %0d delete, %0d get, %0d locate,",
               words_sent, op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_GET],
               op_seen[OP_LOCATE]);
      $display("  %0d clear, %0d unused opcode; list reached %0d of %0d entries,",
               op_seen[OP_CLEAR], unused_ops, peak_length, DEPTH);
      $display("  %0d inserts hit a full list, %0d error responses, %0d mismatches",
               full_rejects, error_responses, error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/pol_pkg.sv
hdl/pol_ifc.sv
hdl/positional_ordered_list_core.sv
dv/testbench.sv
